FILE: src/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, codes and constants of the health-aware backend selector.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int unsigned NUM_BACKENDS = 8;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned LAT_W        = 24;
  localparam int unsigned SCORE_W      = 10;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;

  // x / 10 as (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2^30
  localparam int unsigned SUM_W        = 28;
  localparam int unsigned PROD_W       = 56;
  localparam logic [SUM_W-1:0] DIV10_MUL = 28'd214748365;
  localparam int unsigned DIV10_SHIFT  = 31;

  // opcodes
  localparam logic [2:0] OP_SELECT      = 3'd0;
  localparam logic [2:0] OP_SELECT_PROF = 3'd1;
  localparam logic [2:0] OP_FAILURE     = 3'd2;
  localparam logic [2:0] OP_SUCCESS     = 3'd3;
  localparam logic [2:0] OP_LATENCY     = 3'd4;

  // profiles
  localparam logic [1:0] PROF_AUTO    = 2'd0;
  localparam logic [1:0] PROF_ECONOMY = 2'd1;
  localparam logic [1:0] PROF_PREMIUM = 2'd2;

  // request complexity
  localparam logic [1:0] CX_SIMPLE  = 2'd0;
  localparam logic [1:0] CX_MEDIUM  = 2'd1;
  localparam logic [1:0] CX_COMPLEX = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ROUTE_PROFILE     = 3'd0;
  localparam logic [2:0] REG_PRESENT_MASK      = 3'd1;
  localparam logic [2:0] REG_PRIORITIES        = 3'd2;
  localparam logic [2:0] REG_COST_TIERS        = 3'd3;
  localparam logic [2:0] REG_FAILURE_LIMIT     = 3'd4;
  localparam logic [2:0] REG_RECOVERY_INTERVAL = 3'd5;
  localparam logic [2:0] REG_DEBOUNCE_WINDOW   = 3'd6;
  localparam logic [2:0] REG_MAX_BACKOFF       = 3'd7;

  typedef struct packed {
    logic [1:0]  route_profile;
    logic [7:0]  present_mask;
    logic [31:0] priorities;
    logic [15:0] cost_tiers;
    logic [3:0]  failure_limit;
    logic [7:0]  recovery_interval;
    logic [7:0]  debounce_window;
    logic [7:0]  max_backoff;
  } cfg_t;

endpackage

FILE: src/hbs_cfg.sv
// ----------------------------------------------------------------------------
// hbs_cfg
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module hbs_cfg import hbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ROUTE_PROFILE:     cfg_d.route_profile     = pwdata[1:0];
        REG_PRESENT_MASK:      cfg_d.present_mask      = pwdata[7:0];
        REG_PRIORITIES:        cfg_d.priorities        = pwdata[31:0];
        REG_COST_TIERS:        cfg_d.cost_tiers        = pwdata[15:0];
        REG_FAILURE_LIMIT:     cfg_d.failure_limit     = pwdata[3:0];
        REG_RECOVERY_INTERVAL: cfg_d.recovery_interval = pwdata[7:0];
        REG_DEBOUNCE_WINDOW:   cfg_d.debounce_window   = pwdata[7:0];
        REG_MAX_BACKOFF:       cfg_d.max_backoff       = pwdata[7:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.route_profile     <= PROF_AUTO;
      cfg_q.present_mask      <= 8'd0;
      cfg_q.priorities        <= 32'd0;
      cfg_q.cost_tiers        <= 16'd0;
      cfg_q.failure_limit     <= 4'd3;
      cfg_q.recovery_interval <= 8'd15;
      cfg_q.debounce_window   <= 8'd5;
      cfg_q.max_backoff       <= 8'd60;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROUTE_PROFILE:     prdata = {30'd0, cfg_q.route_profile};
      REG_PRESENT_MASK:      prdata = {24'd0, cfg_q.present_mask};
      REG_PRIORITIES:        prdata = cfg_q.priorities;
      REG_COST_TIERS:        prdata = {16'd0, cfg_q.cost_tiers};
      REG_FAILURE_LIMIT:     prdata = {28'd0, cfg_q.failure_limit};
      REG_RECOVERY_INTERVAL: prdata = {24'd0, cfg_q.recovery_interval};
      REG_DEBOUNCE_WINDOW:   prdata = {24'd0, cfg_q.debounce_window};
      REG_MAX_BACKOFF:       prdata = {24'd0, cfg_q.max_backoff};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/hbs_score.sv
// ----------------------------------------------------------------------------
// hbs_score
// Score of one backend from priority, profile, cost tier, failures and
// latency average; shared by every step of a select scan.
// ----------------------------------------------------------------------------
module hbs_score import hbs_pkg::*; (
  input  logic [3:0]                prio_i,
  input  logic [1:0]                tier_i,
  input  logic [1:0]                profile_i,
  input  logic [1:0]                complexity_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [LAT_W-1:0]          avg_i,
  output logic signed [SCORE_W-1:0] score_o
);

  logic [SCORE_W-1:0] prio_x10;
  logic [SCORE_W-1:0] tier_x30;
  logic [SCORE_W-1:0] econ_x30;
  logic [SCORE_W-1:0] cnt_x15;
  logic [SCORE_W-1:0] prof_bonus;
  logic [3:0]         lat_bonus;
  logic               tier_match;
  logic [1:0]         inv_tier;

  assign inv_tier = ~tier_i;  // 3 - tier
  assign prio_x10 = {3'b0, prio_i, 3'b0} + {5'b0, prio_i, 1'b0};
  assign tier_x30 = {3'b0, tier_i, 5'b0} - {7'b0, tier_i, 1'b0};
  assign econ_x30 = {3'b0, inv_tier, 5'b0} - {7'b0, inv_tier, 1'b0};
  assign cnt_x15  = {2'b0, count_i, 4'b0} - {6'b0, count_i};

  assign tier_match = ((complexity_i == CX_SIMPLE)  && (tier_i <= 2'd1)) ||
                      ((complexity_i == CX_MEDIUM)  && (tier_i == 2'd1)) ||
                      ((complexity_i == CX_COMPLEX) && (tier_i >= 2'd2));

  always_comb begin
    case (profile_i)
      PROF_ECONOMY: prof_bonus = econ_x30;
      PROF_PREMIUM: prof_bonus = tier_x30;
      default:      prof_bonus = tier_match ? SCORE_W'(20) : '0;
    endcase
  end

  // (5000 - avg) / 500 as a count of thresholds passed
  always_comb begin
    lat_bonus = '0;
    for (int k = 1; k <= 9; k++) begin
      if (avg_i <= LAT_W'(5000 - 500 * k)) begin
        lat_bonus = lat_bonus + 4'd1;
      end
    end
    if (avg_i == '0) begin
      lat_bonus = '0;
    end
  end

  assign score_o = $signed(SCORE_W'(100) - prio_x10 + prof_bonus - cnt_x15 +
                           {6'b0, lat_bonus});

endmodule

FILE: src/health_aware_backend_selector_core.sv
// ----------------------------------------------------------------------------
// health_aware_backend_selector_core
// Picks a backend per request and keeps per-backend health state.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid_i / in_stall_o with an opcode and its
// operands; select items produce one result item on out_valid_o /
// out_stall_i, report items produce none. Registers are written over the
// APB-style port; the user must write them only while the block is idle,
// which the block itself does not enforce. A select walks the backend table
// one entry per cycle through a single scoring unit: in_stall_o is high
// through the 8 scan steps and the result step, and the result item shows
// the cycle after the result step. A success report is never busy; a
// failure report is busy for a count update, then backoff; a latency report
// for a weighted sum, multiply by the reciprocal of ten and write back, or
// the sum step alone for a first sample. Reset clears all health state and
// loads the register defaults. A result item waits in the output register
// while the receiver stalls; the next item is still accepted, and a later
// select holds in its result step until the output register is free.
// ----------------------------------------------------------------------------
module health_aware_backend_selector_core import hbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        opcode_i,
  input  logic [TIME_W-1:0] now_seconds_i,
  input  logic [1:0]        complexity_i,
  input  logic [1:0]        profile_override_i,
  input  logic [IDX_W-1:0]  backend_index_i,
  input  logic [LAT_W-1:0]  latency_sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  selected_backend_o,
  output logic              selection_valid_o,
  output logic              from_fallback_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RES  = 3'd2;
  localparam logic [2:0] ST_FAIL = 3'd3;
  localparam logic [2:0] ST_BOFF = 3'd4;
  localparam logic [2:0] ST_LSUM = 3'd5;
  localparam logic [2:0] ST_LMUL = 3'd6;
  localparam logic [2:0] ST_LWR  = 3'd7;

  cfg_t cfg;

  hbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [2:0] state_q, state_d;

  // health table
  logic [CNT_W-1:0]  cnt_q  [NUM_BACKENDS];
  logic [TIME_W-1:0] last_q [NUM_BACKENDS];
  logic [TIME_W-1:0] dl_q   [NUM_BACKENDS];
  logic [LAT_W-1:0]  avg_q  [NUM_BACKENDS];

  // latched item
  logic [TIME_W-1:0] now_q;
  logic [1:0]        cx_q;
  logic [1:0]        prof_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LAT_W-1:0]  sample_q;

  // scan bookkeeping
  logic [IDX_W-1:0]          scan_q;
  logic signed [SCORE_W-1:0] top_score_q;
  logic [IDX_W-1:0]          best_idx_q;
  logic                      best_found_q;
  logic [TIME_W-1:0]         fb_until_q;
  logic [IDX_W-1:0]          fb_idx_q;
  logic                      fb_found_q;

  // latency datapath
  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] prod_q;

  // output register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_sel_q;
  logic             out_selv_q;
  logic             out_fb_q;

  logic in_accept;
  logic res_load;
  logic scan_last;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign res_load = (state_q == ST_RES) & (~out_valid_q | ~out_stall_i);
  assign scan_last = (scan_q == IDX_W'(NUM_BACKENDS - 1));

  // one table read port
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  r_cnt;
  logic [TIME_W-1:0] r_last;
  logic [TIME_W-1:0] r_dl;
  logic [LAT_W-1:0]  r_avg;

  assign rd_idx = (state_q == ST_SCAN) ? scan_q : idx_q;
  assign r_cnt  = cnt_q[rd_idx];
  assign r_last = last_q[rd_idx];
  assign r_dl   = dl_q[rd_idx];
  assign r_avg  = avg_q[rd_idx];

  // scan step
  logic                      present;
  logic                      in_backoff;
  logic                      need_rest;
  logic                      rested;
  logic                      cand;
  logic                      recover;
  logic                      better;
  logic                      fb_better;
  logic [CNT_W-1:0]          eff_cnt;
  logic [TIME_W-1:0]         since_fail;
  logic signed [SCORE_W-1:0] score;

  assign present    = cfg.present_mask[rd_idx];
  assign in_backoff = (r_dl > now_q);
  assign since_fail = now_q - r_last;
  assign need_rest  = (r_cnt >= cfg.failure_limit);
  assign rested     = (since_fail >= {24'd0, cfg.recovery_interval});
  assign eff_cnt    = need_rest ? '0 : r_cnt;
  assign cand       = present & ~in_backoff & (~need_rest | rested);
  assign recover    = (state_q == ST_SCAN) & present & ~in_backoff & need_rest & rested;
  assign better     = cand & (score > top_score_q);
  assign fb_better  = present & in_backoff & (r_dl < fb_until_q);

  hbs_score u_score (
    .prio_i       (cfg.priorities[4*rd_idx +: 4]),
    .tier_i       (cfg.cost_tiers[2*rd_idx +: 2]),
    .profile_i    (prof_q),
    .complexity_i (cx_q),
    .count_i      (eff_cnt),
    .avg_i        (r_avg),
    .score_o      (score)
  );

  // failure count with debounce
  logic             fail_inc;
  logic [CNT_W-1:0] fail_cnt;

  assign fail_inc = (since_fail >= {24'd0, cfg.debounce_window}) && (r_cnt != '1);
  assign fail_cnt = r_cnt + CNT_W'(fail_inc);

  // capped exponential backoff from the updated count
  logic [2:0]        bo_shift;
  logic [7:0]        bo_raw;
  logic [7:0]        bo;
  logic [TIME_W-1:0] new_dl;
  logic [CNT_W-1:0]  cnt_m2;

  assign cnt_m2   = r_cnt - CNT_W'(2);
  assign bo_shift = (cnt_m2 > CNT_W'(5)) ? 3'd5 : cnt_m2[2:0];

  always_comb begin
    bo_raw = '0;
    if (r_cnt >= CNT_W'(2)) begin
      bo_raw = 8'd2 << bo_shift;
    end
    bo = (bo_raw > cfg.max_backoff) ? cfg.max_backoff : bo_raw;
    new_dl = (bo != '0) ? (now_q + {24'd0, bo}) : '0;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (opcode_i == OP_SELECT || opcode_i == OP_SELECT_PROF) begin
            state_d = ST_SCAN;
          end else if (opcode_i == OP_FAILURE) begin
            state_d = ST_FAIL;
          end else if (opcode_i == OP_LATENCY) begin
            state_d = ST_LSUM;
          end
        end
      end
      ST_SCAN: if (scan_last) state_d = ST_RES;
      ST_RES:  if (res_load) state_d = ST_IDLE;
      ST_FAIL: state_d = ST_BOFF;
      ST_BOFF: state_d = ST_IDLE;
      ST_LSUM: state_d = (r_avg == '0) ? ST_IDLE : ST_LMUL;
      ST_LMUL: state_d = ST_LWR;
      ST_LWR:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item latch and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= '0;
      best_found_q <= 1'b0;
      fb_found_q   <= 1'b0;
      top_score_q  <= '1;
      fb_until_q   <= '1;
    end else if (in_accept) begin
      scan_q       <= '0;
      best_found_q <= 1'b0;
      fb_found_q   <= 1'b0;
      top_score_q  <= '1;  // minus one: a winner needs a score of zero or more
      fb_until_q   <= '1;
    end else if (state_q == ST_SCAN) begin
      scan_q <= scan_q + IDX_W'(1);
      if (better) begin
        top_score_q  <= score;
        best_found_q <= 1'b1;
      end
      if (fb_better) begin
        fb_until_q <= r_dl;
        fb_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q    <= now_seconds_i;
      cx_q     <= complexity_i;
      prof_q   <= (opcode_i == OP_SELECT) ? cfg.route_profile : profile_override_i;
      idx_q    <= backend_index_i;
      sample_q <= latency_sample_i;
    end
    if (state_q == ST_SCAN && better) begin
      best_idx_q <= scan_q;
    end
    if (state_q == ST_SCAN && fb_better) begin
      fb_idx_q <= scan_q;
    end
    if (state_q == ST_LSUM) begin
      sum_q <= ({4'd0, r_avg} << 3) - {4'd0, r_avg} +
               ({4'd0, sample_q} << 1) + {4'd0, sample_q};
    end
    if (state_q == ST_LMUL) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(DIV10_MUL);
    end
  end

  // health table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BACKENDS; i++) begin
        cnt_q[i]  <= '0;
        last_q[i] <= '0;
        dl_q[i]   <= '0;
        avg_q[i]  <= '0;
      end
    end else begin
      if (in_accept && opcode_i == OP_SUCCESS) begin
        cnt_q[backend_index_i] <= '0;
        dl_q[backend_index_i]  <= '0;
      end
      // a rested backend gets its count cleared whether or not it wins
      if (recover) begin
        cnt_q[rd_idx] <= '0;
      end
      if (state_q == ST_FAIL) begin
        cnt_q[idx_q]  <= fail_cnt;
        last_q[idx_q] <= now_q;
      end
      if (state_q == ST_BOFF) begin
        dl_q[idx_q] <= new_dl;
      end
      if (state_q == ST_LSUM && r_avg == '0) begin
        avg_q[idx_q] <= sample_q;
      end
      if (state_q == ST_LWR) begin
        avg_q[idx_q] <= prod_q[DIV10_SHIFT +: LAT_W];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      if (best_found_q) begin
        out_sel_q  <= best_idx_q;
        out_selv_q <= 1'b1;
        out_fb_q   <= 1'b0;
      end else if (fb_found_q) begin
        out_sel_q  <= fb_idx_q;
        out_selv_q <= 1'b1;
        out_fb_q   <= 1'b1;
      end else begin
        out_sel_q  <= '0;
        out_selv_q <= 1'b0;
        out_fb_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign selected_backend_o = out_sel_q;
  assign selection_valid_o  = out_selv_q;
  assign from_fallback_o    = out_fb_q;

endmodule

FILE: dv/hbs_selection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_selection_checker
// Mirrors the register writes and the per-backend health table, predicts the
// backend choice of every select item and compares it with the result items.
// ----------------------------------------------------------------------------
module hbs_selection_checker import hbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [2:0]        opcode_i,
  input  logic [TIME_W-1:0] now_seconds_i,
  input  logic [1:0]        complexity_i,
  input  logic [1:0]        profile_override_i,
  input  logic [IDX_W-1:0]  backend_index_i,
  input  logic [LAT_W-1:0]  latency_sample_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [IDX_W-1:0]  selected_backend_i,
  input  logic              selection_valid_i,
  input  logic              from_fallback_i,
  output int                mismatch_count_o,
  output int                pending_o,
  output int                results_o,
  output int                fallback_results_o,
  output int                unchosen_results_o
);

  typedef struct packed {
    logic [IDX_W-1:0] backend;
    logic             chosen;
    logic             fallback;
  } choice_t;

  cfg_t              shadow_cfg;
  logic [CNT_W-1:0]  fail_cnt  [NUM_BACKENDS];
  logic [TIME_W-1:0] last_fail [NUM_BACKENDS];
  logic [TIME_W-1:0] deadline  [NUM_BACKENDS];
  logic [LAT_W-1:0]  lat_avg   [NUM_BACKENDS];

  choice_t pending_choices[$];
  int      mismatches;
  int      results;
  int      fallbacks;
  int      unchosen;

  // applies one item to the health table, returns 1 for every select item
  function automatic bit choose_and_update_health(
    output choice_t          pick,
    input  logic [2:0]       op,
    input  logic [TIME_W-1:0] now,
    input  logic [1:0]       cx,
    input  logic [1:0]       prof,
    input  logic [IDX_W-1:0] idx,
    input  logic [LAT_W-1:0] lat
  );
    int          best;
    int          fb;
    int          top_score;
    int          s;
    int          prio;
    int          tier;
    int          sh;
    bit          eligible;
    logic [1:0]  profile;
    logic [31:0] fb_until;
    logic [31:0] rest;
    logic [31:0] bo;
    logic [63:0] blend;
    pick = '0;
    case (op)
      OP_SELECT, OP_SELECT_PROF: begin
        profile    = (op == OP_SELECT) ? shadow_cfg.route_profile : prof;
        best       = -1;
        fb         = -1;
        top_score  = -1;
        fb_until   = '1;
        for (int i = 0; i < NUM_BACKENDS; i++) begin
          if (shadow_cfg.present_mask[i]) begin
            if (deadline[i] > now) begin
              // earliest deadline in backoff, ties keep the lower index
              if (deadline[i] < fb_until) begin
                fb_until = deadline[i];
                fb       = i;
              end
            end else begin
              eligible = 1'b1;
              rest     = now - last_fail[i];
              if (fail_cnt[i] >= shadow_cfg.failure_limit) begin
                // recovery clears the count even if this backend loses
                if (rest >= 32'(shadow_cfg.recovery_interval)) fail_cnt[i] = '0;
                else eligible = 1'b0;
              end
              if (eligible) begin
                prio = int'(shadow_cfg.priorities[4*i +: 4]);
                tier = int'(shadow_cfg.cost_tiers[2*i +: 2]);
                s    = 100 - 10 * prio;
                if (profile == PROF_ECONOMY) begin
                  s += 30 * (3 - tier);
                end else if (profile == PROF_PREMIUM) begin
                  s += 30 * tier;
                end else if ((cx == CX_SIMPLE && tier <= 1) ||
                             (cx == CX_MEDIUM && tier == 1) ||
                             (cx == CX_COMPLEX && tier >= 2)) begin
                  s += 20;
                end
                s -= 15 * int'(fail_cnt[i]);
                if (lat_avg[i] != '0 && lat_avg[i] < 24'd5000) begin
                  s += (5000 - int'(lat_avg[i])) / 500;
                end
                if (s > top_score) begin
                  top_score = s;
                  best      = i;
                end
              end
            end
          end
        end
        if (best >= 0) pick = '{IDX_W'(best), 1'b1, 1'b0};
        else if (fb >= 0) pick = '{IDX_W'(fb), 1'b1, 1'b1};
        return 1'b1;
      end
      OP_FAILURE: begin
        rest = now - last_fail[idx];
        if (rest >= 32'(shadow_cfg.debounce_window) && fail_cnt[idx] != '1) begin
          fail_cnt[idx] = fail_cnt[idx] + 1'b1;
        end
        last_fail[idx] = now;
        bo = '0;
        if (fail_cnt[idx] >= 2) begin
          sh = int'(fail_cnt[idx]) - 2;
          if (sh > 5) sh = 5;
          bo = 32'd2 << sh;
          if (bo > 32'(shadow_cfg.max_backoff)) bo = 32'(shadow_cfg.max_backoff);
        end
        deadline[idx] = (bo != '0) ? now + bo : '0;
      end
      OP_SUCCESS: begin
        fail_cnt[idx] = '0;
        deadline[idx] = '0;
      end
      OP_LATENCY: begin
        if (lat_avg[idx] == '0) begin
          lat_avg[idx] = lat;
        end else begin
          blend        = (64'(lat_avg[idx]) * 7 + 64'(lat) * 3) / 10;
          lat_avg[idx] = blend[LAT_W-1:0];
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    choice_t want;
    choice_t got;
    if (!rst_ni) begin
      shadow_cfg                   = '0;
      shadow_cfg.failure_limit     = 4'd3;
      shadow_cfg.recovery_interval = 8'd15;
      shadow_cfg.debounce_window   = 8'd5;
      shadow_cfg.max_backoff       = 8'd60;
      for (int i = 0; i < NUM_BACKENDS; i++) begin
        fail_cnt[i]  = '0;
        last_fail[i] = '0;
        deadline[i]  = '0;
        lat_avg[i]   = '0;
      end
      pending_choices.delete();
      mismatches = 0;
      results    = 0;
      fallbacks  = 0;
      unchosen   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ROUTE_PROFILE:     shadow_cfg.route_profile     = pwdata[1:0];
          REG_PRESENT_MASK:      shadow_cfg.present_mask      = pwdata[7:0];
          REG_PRIORITIES:        shadow_cfg.priorities        = pwdata[31:0];
          REG_COST_TIERS:        shadow_cfg.cost_tiers        = pwdata[15:0];
          REG_FAILURE_LIMIT:     shadow_cfg.failure_limit     = pwdata[3:0];
          REG_RECOVERY_INTERVAL: shadow_cfg.recovery_interval = pwdata[7:0];
          REG_DEBOUNCE_WINDOW:   shadow_cfg.debounce_window   = pwdata[7:0];
          REG_MAX_BACKOFF:       shadow_cfg.max_backoff       = pwdata[7:0];
          default: ;
        endcase
      end
      // a result item always belongs to an earlier select, so pop before push
      if (out_valid_i && !out_stall_i) begin
        got = '{selected_backend_i, selection_valid_i, from_fallback_i};
        if (pending_choices.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing pending: backend %0d valid %0b fallback %0b",
                     $realtime, got.backend, got.chosen, got.fallback);
          end
          mismatches++;
        end else begin
          want = pending_choices.pop_front();
          results++;
          if (want.fallback) fallbacks++;
          if (!want.chosen) unchosen++;
          if (got.backend !== want.backend || got.chosen !== want.chosen ||
              got.fallback !== want.fallback) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: expected backend %0d valid %0b fallback %0b,",
                       $realtime, want.backend, want.chosen, want.fallback);
              $display("    got backend %0d valid %0b fallback %0b",
                       got.backend, got.chosen, got.fallback);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (choose_and_update_health(want, opcode_i, now_seconds_i, complexity_i,
                                     profile_override_i, backend_index_i,
                                     latency_sample_i)) begin
          pending_choices.push_back(want);
        end
      end
    end
    mismatch_count_o   <= mismatches;
    pending_o          <= pending_choices.size();
    results_o          <= results;
    fallback_results_o <= fallbacks;
    unchosen_results_o <= unchosen;
  end

endmodule

FILE: dv/health_aware_backend_selector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// health_aware_backend_selector_core_tb
// Drives directed and random select and report items through several register
// settings with random idling on both channels; the checker grades results.
// ----------------------------------------------------------------------------
module health_aware_backend_selector_core_tb;
  import hbs_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  localparam logic [1:0]  CX_RESERVED   = 2'd3;
  localparam logic [1:0]  PROF_RESERVED = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        opcode_i;
  logic [TIME_W-1:0] now_seconds_i;
  logic [1:0]        complexity_i;
  logic [1:0]        profile_override_i;
  logic [IDX_W-1:0]  backend_index_i;
  logic [LAT_W-1:0]  latency_sample_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IDX_W-1:0]  selected_backend_o;
  logic              selection_valid_o;
  logic              from_fallback_o;

  int mismatch_count;
  int pending_count;
  int result_count;
  int fallback_count;
  int unchosen_count;

  int          item_count;
  int          cfg_count;
  int          calm_left;
  logic [31:0] t_now;

  health_aware_backend_selector_core dut (.*);

  hbs_selection_checker selection_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .opcode_i           (opcode_i),
    .now_seconds_i      (now_seconds_i),
    .complexity_i       (complexity_i),
    .profile_override_i (profile_override_i),
    .backend_index_i    (backend_index_i),
    .latency_sample_i   (latency_sample_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .selected_backend_i (selected_backend_o),
    .selection_valid_i  (selection_valid_o),
    .from_fallback_i    (from_fallback_o),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending_count),
    .results_o          (result_count),
    .fallback_results_o (fallback_count),
    .unchosen_results_o (unchosen_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL health_aware_backend_selector_core");
    $finish;
  end

  // receiver stall: mostly short bursts, now and then a long one or a calm stretch
  initial begin
    int   r;
    int   len;
    logic level;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        level = 1'b0;
        len   = $urandom_range(1, 20);
      end else if (r < 90) begin
        level = 1'b1;
        len   = $urandom_range(1, 3);
      end else if (r < 97) begin
        level = 1'b1;
        len   = $urandom_range(8, 40);
      end else begin
        level = 1'b0;
        len   = $urandom_range(100, 300);
      end
      repeat (len) begin
        @(posedge clk_i);
        out_stall_i <= level;
      end
    end
  end

  task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t c);
    apb_write(REG_ROUTE_PROFILE,     32'(c.route_profile));
    apb_write(REG_PRESENT_MASK,      32'(c.present_mask));
    apb_write(REG_PRIORITIES,        c.priorities);
    apb_write(REG_COST_TIERS,        32'(c.cost_tiers));
    apb_write(REG_FAILURE_LIMIT,     32'(c.failure_limit));
    apb_write(REG_RECOVERY_INTERVAL, 32'(c.recovery_interval));
    apb_write(REG_DEBOUNCE_WINDOW,   32'(c.debounce_window));
    apb_write(REG_MAX_BACKOFF,       32'(c.max_backoff));
    cfg_count++;
  endtask

  // called at a clock step; returns at a clock step after the item is taken
  task automatic send_item(input logic [2:0] op, input logic [31:0] now,
                           input logic [1:0] cx, input logic [1:0] prof,
                           input logic [2:0] idx, input logic [23:0] lat);
    int gap;
    int r;
    opcode_i           <= op;
    now_seconds_i      <= now;
    complexity_i       <= cx;
    profile_override_i <= prof;
    backend_index_i    <= idx;
    latency_sample_i   <= lat;
    in_valid_i         <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    item_count++;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        calm_left = $urandom_range(20, 60);
        gap = 0;
      end else if (r < 50) begin
        gap = 0;
      end else if (r < 85) begin
        gap = $urandom_range(1, 3);
      end else if (r < 97) begin
        gap = $urandom_range(4, 12);
      end else begin
        gap = $urandom_range(20, 60);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every pending choice is out and reports settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(input cfg_t c, input int n_items);
    int          r;
    int          burst;
    logic [2:0]  burst_idx;
    logic [2:0]  op;
    logic [2:0]  idx;
    logic [23:0] lat;
    drain();
    load_settings(c);
    burst     = 0;
    burst_idx = '0;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (burst > 0) t_now = t_now + 32'(c.debounce_window) + $urandom_range(0, 1);
      else if (r < 70) t_now = t_now + $urandom_range(0, 3);
      else if (r < 90) t_now = t_now + $urandom_range(4, 20);
      else if (r < 97) t_now = t_now + $urandom_range(21, 300);
      else t_now = $urandom;
      if (c.present_mask != '0 && $urandom_range(0, 4) != 0) begin
        do idx = 3'($urandom_range(0, 7)); while (!c.present_mask[idx]);
      end else begin
        idx = 3'($urandom_range(0, 7));
      end
      if (burst > 0) begin
        op  = OP_FAILURE;
        idx = burst_idx;
        burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_SELECT;
        else if (r < 50) op = OP_SELECT_PROF;
        else if (r < 72) op = OP_FAILURE;
        else if (r < 82) op = OP_SUCCESS;
        else if (r < 96) op = OP_LATENCY;
        else op = OP_LATENCY + 3'($urandom_range(1, 3));
        // back-to-back counted failures drive a backend to its limit and saturation
        if (op == OP_FAILURE && $urandom_range(0, 19) == 0) begin
          burst     = $urandom_range(10, 18);
          burst_idx = idx;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 70) lat = 24'($urandom_range(1, 6000));
      else if (r < 85) lat = 24'($urandom_range(0, 200));
      else lat = 24'($urandom);
      send_item(op, t_now, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), idx, lat);
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    cfg_t c;
    int   n;
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_valid_i         <= 1'b0;
    opcode_i           <= OP_SELECT;
    now_seconds_i      <= '0;
    complexity_i       <= CX_SIMPLE;
    profile_override_i <= PROF_AUTO;
    backend_index_i    <= '0;
    latency_sample_i   <= '0;
    item_count = 0;
    cfg_count  = 0;
    calm_left  = 0;
    t_now      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // backends 0, 1 and 7 present, tiers 0, 2 and 3
    c.route_profile     = PROF_AUTO;
    c.present_mask      = 8'h83;
    c.priorities        = 32'h5000_0030;
    c.cost_tiers        = 16'hC008;
    c.failure_limit     = 4'd3;
    c.recovery_interval = 8'd15;
    c.debounce_window   = 8'd5;
    c.max_backoff       = 8'd60;
    load_settings(c);

    send_item(OP_SELECT,      32'd0, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_SELECT_PROF, 32'd1, CX_MEDIUM,   PROF_ECONOMY,  3'd1, 24'd0);
    send_item(OP_SELECT_PROF, 32'd2, CX_COMPLEX,  PROF_PREMIUM,  3'd2, 24'd0);
    send_item(OP_SELECT_PROF, 32'd3, CX_RESERVED, PROF_RESERVED, 3'd3, 24'd0);
    send_item(OP_LATENCY,     32'd4, CX_SIMPLE,   PROF_AUTO,     3'd1, 24'hFFFFFF);
    send_item(OP_LATENCY,     32'd5, CX_SIMPLE,   PROF_AUTO,     3'd1, 24'd0);
    send_item(OP_LATENCY,     32'd6, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd1234);
    // second failure inside the debounce window is not counted
    send_item(OP_FAILURE,   32'd100, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_FAILURE,   32'd102, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_FAILURE,   32'd110, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_FAILURE,   32'd100, CX_SIMPLE,   PROF_AUTO,     3'd1, 24'd0);
    send_item(OP_FAILURE,   32'd110, CX_SIMPLE,   PROF_AUTO,     3'd1, 24'd0);
    send_item(OP_FAILURE,   32'd100, CX_SIMPLE,   PROF_AUTO,     3'd7, 24'd0);
    send_item(OP_FAILURE,   32'd109, CX_SIMPLE,   PROF_AUTO,     3'd7, 24'd0);
    // all in backoff: earliest deadline wins as fallback, then all back
    send_item(OP_SELECT,    32'd110, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_SELECT,    32'd112, CX_COMPLEX,  PROF_AUTO,     3'd0, 24'd0);
    // third failure reaches the limit; skipped until rested, then cleared
    send_item(OP_FAILURE,   32'd120, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_SELECT,    32'd125, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_SELECT,    32'd135, CX_SIMPLE,   PROF_AUTO,     3'd0, 24'd0);
    send_item(OP_SUCCESS,   32'd136, CX_SIMPLE,   PROF_AUTO,     3'd1, 24'd0);
    send_item(OP_LATENCY + 3'd1, 32'd137, CX_SIMPLE, PROF_AUTO,  3'd7, 24'hFFFFFF);
    send_item(OP_LATENCY + 3'd2, 32'd138, CX_SIMPLE, PROF_AUTO,  3'd7, 24'hFFFFFF);
    send_item(OP_LATENCY + 3'd3, 32'd139, CX_SIMPLE, PROF_AUTO,  3'd7, 24'hFFFFFF);
    // deadline wraps past zero
    send_item(OP_FAILURE,   32'hFFFF_FFFD, CX_SIMPLE, PROF_AUTO, 3'd7, 24'd0);
    send_item(OP_SELECT,    32'hFFFF_FFFE, CX_MEDIUM, PROF_AUTO, 3'd0, 24'd0);

    t_now = $urandom;
    for (int p = 0; p < 9; p++) begin
      c.route_profile     = 2'($urandom_range(0, 2));
      c.present_mask      = 8'($urandom_range(1, 255));
      c.priorities        = $urandom;
      c.cost_tiers        = 16'($urandom);
      c.failure_limit     = 4'($urandom_range(1, 6));
      c.recovery_interval = 8'($urandom_range(0, 40));
      c.debounce_window   = 8'($urandom_range(0, 8));
      c.max_backoff       = 8'($urandom_range(0, 80));
      n = 130;
      case (p)
        0: begin
          c.failure_limit     = 4'd1;
          c.recovery_interval = 8'd0;
          c.debounce_window   = 8'd0;
          c.max_backoff       = 8'd255;
          c.priorities        = '0;
          c.cost_tiers        = '0;
          c.present_mask      = 8'hFF;
        end
        1: begin
          c.failure_limit     = 4'd15;
          c.recovery_interval = 8'd255;
          c.debounce_window   = 8'd255;
          c.max_backoff       = 8'd0;
          c.priorities        = '1;
          c.cost_tiers        = '1;
          c.route_profile     = PROF_ECONOMY;
        end
        2: begin
          // a zero limit sends every backend outside backoff through the rest test
          c.failure_limit     = 4'd0;
          c.debounce_window   = 8'd0;
          c.max_backoff       = 8'd1;
          c.route_profile     = PROF_PREMIUM;
          c.present_mask      = 8'h01;
        end
        3: begin
          c.present_mask      = 8'h00;
          c.route_profile     = PROF_RESERVED;
          n = 40;
        end
        4: begin
          c.present_mask      = 8'h80;
          c.failure_limit     = 4'd15;
          c.recovery_interval = 8'd255;
          c.debounce_window   = 8'd0;
          c.route_profile     = PROF_AUTO;
        end
        default: ;
      endcase
      run_phase(c, n);
    end
    drain();

    $display("%0d items sent under %0d register settings", item_count, cfg_count);
    $display("%0d choices checked: %0d from backoff fallback, %0d with no backend",
             result_count, fallback_count, unchosen_count);
    if (pending_count != 0) $display("%0d choices never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS health_aware_backend_selector_core");
    end else begin
      $display("FAIL health_aware_backend_selector_core");
    end
    $finish;
  end

endmodule
